// File: rtl/pfrm_pkg.sv
package pfrm_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_PACKET = 2'd0,
		OP_MOVE   = 2'd1,
		OP_QUERY  = 2'd2,
		OP_RESET  = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAX_PKTS  = 2'd0,
		CFG_WINDOW    = 2'd1,
		CFG_MAX_SPEED = 2'd2,
		CFG_KICK_THR  = 2'd3
	} cfg_idx_t;

	localparam logic [5:0]  MAX_PKTS_RST  = 6'd60;
	localparam logic [31:0] WINDOW_RST    = 32'd1000000;
	localparam logic [31:0] MAX_SPEED_RST = 32'd1310720;
	localparam logic [15:0] KICK_THR_RST  = 16'd10;
	localparam logic [15:0] SUSP_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [5:0]  max_pkts;
		logic [31:0] window;
		logic [31:0] max_speed;
		logic [15:0] kick_thr;
	} cfg_t;

	// Multiply sequence of the speed check
	typedef enum logic [2:0] {
		MS_DX    = 3'd0,
		MS_DY    = 3'd1,
		MS_DZ    = 3'd2,
		MS_L     = 3'd3,
		MS_LL    = 3'd4,
		MS_LH    = 3'd5,
		MS_HH    = 3'd6,
		MS_DRAIN = 3'd7
	} mul_step_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_LD,
		ST_PK_RD,
		ST_PK_CMP,
		ST_PK_PUSH,
		ST_MV_DIFF,
		ST_MV_MUL,
		ST_MV_CMP,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      row_rd;
		logic      row_ld;
		logic      stamp_rd;
		logic      pop;
		logic      push;
		logic      mv_first;
		logic      diff;
		logic      mul;
		mul_step_t mul_step;
		logic      mv_cmp;
		logic      row_wr;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic in_range;
		logic count_nz;
		logic expired;
		logic entry_valid;
		logic dt_pos;
	} status_t;

	typedef struct packed {
		logic        passed;
		logic [15:0] susp;
		logic [6:0]  rate;
	} result_t;

endpackage

// File: rtl/pfrm_ctrl.sv
module pfrm_ctrl
	import pfrm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    out_busy,
	input  status_t status,
	output cmd_t    cmd
);

	state_t    state_q, state_d;
	mul_step_t step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= MS_DX;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MV_DIFF)
				step_q <= MS_DX;
			else if (state_q == ST_MV_MUL)
				step_q <= mul_step_t'(step_q + 3'd1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_ROW_RD;
			ST_ROW_RD:  state_d = ST_ROW_LD;
			ST_ROW_LD: begin
				if (!status.in_range)
					state_d = ST_OUT;
				else begin
					unique case (status.op)
						OP_PACKET: state_d = ST_PK_RD;
						OP_MOVE:   state_d = ST_MV_DIFF;
						OP_RESET:  state_d = ST_WRITE;
						default:   state_d = ST_OUT;
					endcase
				end
			end
			ST_PK_RD:   state_d = status.count_nz ? ST_PK_CMP : ST_PK_PUSH;
			ST_PK_CMP:  state_d = status.expired ? ST_PK_RD : ST_PK_PUSH;
			ST_PK_PUSH: state_d = ST_WRITE;
			ST_MV_DIFF: begin
				if (!status.entry_valid)
					state_d = ST_WRITE;
				else if (!status.dt_pos)
					state_d = ST_OUT;
				else
					state_d = ST_MV_MUL;
			end
			ST_MV_MUL:  if (step_q == MS_DRAIN) state_d = ST_MV_CMP;
			ST_MV_CMP:  state_d = ST_WRITE;
			ST_WRITE:   state_d = ST_OUT;
			ST_OUT:     if (!out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_step = step_q;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			ST_ROW_RD:  cmd.row_rd = 1'b1;
			ST_ROW_LD:  cmd.row_ld = 1'b1;
			ST_PK_RD:   cmd.stamp_rd = status.count_nz;
			ST_PK_CMP:  cmd.pop = status.expired;
			ST_PK_PUSH: cmd.push = 1'b1;
			ST_MV_DIFF: begin
				cmd.mv_first = !status.entry_valid;
				cmd.diff     = status.entry_valid && status.dt_pos;
			end
			ST_MV_MUL:  cmd.mul = 1'b1;
			ST_MV_CMP:  cmd.mv_cmp = 1'b1;
			ST_WRITE:   cmd.row_wr = 1'b1;
			ST_OUT:     cmd.out_load = !out_busy;
			default:    cmd = '0;
		endcase
	end

endmodule

// File: rtl/pfrm_dp.sv
module pfrm_dp
	import pfrm_pkg::*;
#(
	parameter int PLAYERS     = 64,
	parameter int STAMP_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic        [1:0]  operation,
	input  logic        [5:0]  player,
	input  logic        [31:0] now_time,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] delta_time,
	output status_t            status,
	output result_t            result
);

	localparam int PIW   = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
	localparam int HW    = $clog2(STAMP_DEPTH);
	localparam int CW    = $clog2(STAMP_DEPTH + 1);
	localparam int RINGS = PLAYERS * STAMP_DEPTH;
	localparam int AW    = $clog2(RINGS);

	// item registers
	op_t                op_q;
	logic        [5:0]  player_q;
	logic        [31:0] now_q;
	logic signed [31:0] x_q, y_q, z_q, dt_q;

	// per-player tables
	logic        [PLAYERS-1:0] init_q;
	logic                      m_valid [PLAYERS];
	logic signed [31:0]        m_x     [PLAYERS];
	logic signed [31:0]        m_y     [PLAYERS];
	logic signed [31:0]        m_z     [PLAYERS];
	logic        [15:0]        m_susp  [PLAYERS];
	logic        [HW-1:0]      m_head  [PLAYERS];
	logic        [CW-1:0]      m_count [PLAYERS];
	logic        [31:0]        ring    [RINGS];

	// row read data
	logic               rd_init_q, rd_valid_q;
	logic signed [31:0] rd_x_q, rd_y_q, rd_z_q;
	logic        [15:0] rd_susp_q;
	logic [HW-1:0]      rd_head_q;
	logic [CW-1:0]      rd_count_q;

	// working copy of the row
	logic               valid_q, pass_q;
	logic signed [31:0] lx_q, ly_q, lz_q;
	logic        [15:0] susp_q;
	logic [HW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic        [31:0] stamp_q;

	// speed check
	logic [32:0]  adx_q, ady_q, adz_q;
	logic [65:0]  prod_q;
	logic         pvld_q;
	mul_step_t    pstep_q;
	logic [62:0]  l_q;
	logic [67:0]  dist_q;
	logic [127:0] lim_q;

	logic [PIW-1:0] idx;
	logic           in_range;
	logic [AW-1:0]  base;
	logic [HW-1:0]  head_inc, h1;
	logic [CW-1:0]  c1, c_new;
	logic [CW:0]    pos_sum;
	logic [HW-1:0]  wpos;
	logic [32:0]    ma, mb;
	logic [62:0]    lsrc;
	logic [15:0]    susp_inc;
	logic signed [32:0] dx, dy, dz;

	assign idx      = PIW'(player_q);
	assign in_range = 32'(player_q) < PLAYERS;
	assign base     = AW'(32'(idx) * STAMP_DEPTH);
	assign head_inc = (32'(head_q) == STAMP_DEPTH - 1) ? '0 : head_q + 1'b1;
	assign susp_inc = (susp_q == SUSP_MAX) ? susp_q : susp_q + 16'd1;

	// drop the oldest stamp when the ring is full, then append
	always_comb begin
		if (32'(count_q) == STAMP_DEPTH) begin
			h1 = head_inc;
			c1 = CW'(STAMP_DEPTH - 1);
		end else begin
			h1 = head_q;
			c1 = count_q;
		end
		pos_sum = (CW+1)'(h1) + (CW+1)'(c1);
		if (32'(pos_sum) >= STAMP_DEPTH)
			wpos = HW'(32'(pos_sum) - STAMP_DEPTH);
		else
			wpos = HW'(pos_sum);
		c_new = c1 + 1'b1;
	end

	assign dx = 33'(x_q) - 33'(lx_q);
	assign dy = 33'(y_q) - 33'(ly_q);
	assign dz = 33'(z_q) - 33'(lz_q);

	// l = max_speed * dt, squared as three partial products
	always_comb begin
		lsrc = (cmd.mul_step == MS_LL) ? prod_q[62:0] : l_q;
		ma   = '0;
		mb   = '0;
		case (cmd.mul_step)
			MS_DX: begin ma = adx_q; mb = adx_q; end
			MS_DY: begin ma = ady_q; mb = ady_q; end
			MS_DZ: begin ma = adz_q; mb = adz_q; end
			MS_L:  begin ma = {1'b0, cfg.max_speed}; mb = {2'b0, dt_q[30:0]}; end
			MS_LL: begin ma = {1'b0, lsrc[31:0]}; mb = {1'b0, lsrc[31:0]}; end
			MS_LH: begin ma = {2'b0, lsrc[62:32]}; mb = {1'b0, lsrc[31:0]}; end
			MS_HH: begin ma = {2'b0, lsrc[62:32]}; mb = {2'b0, lsrc[62:32]}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			pvld_q <= 1'b0;
		end else begin
			if (cmd.row_wr)
				init_q[idx] <= 1'b1;
			if (cmd.diff)
				pvld_q <= 1'b0;
			else if (cmd.mul)
				pvld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= op_t'(operation);
			player_q <= player;
			now_q    <= now_time;
			x_q      <= pos_x;
			y_q      <= pos_y;
			z_q      <= pos_z;
			dt_q     <= delta_time;
		end
		if (cmd.row_rd) begin
			rd_init_q  <= init_q[idx];
			rd_valid_q <= m_valid[idx];
			rd_x_q     <= m_x[idx];
			rd_y_q     <= m_y[idx];
			rd_z_q     <= m_z[idx];
			rd_susp_q  <= m_susp[idx];
			rd_head_q  <= m_head[idx];
			rd_count_q <= m_count[idx];
		end
		if (cmd.row_wr) begin
			m_valid[idx] <= valid_q;
			m_x[idx]     <= lx_q;
			m_y[idx]     <= ly_q;
			m_z[idx]     <= lz_q;
			m_susp[idx]  <= susp_q;
			m_head[idx]  <= head_q;
			m_count[idx] <= count_q;
		end
		if (cmd.stamp_rd)
			stamp_q <= ring[base + AW'(head_q)];
		if (cmd.push)
			ring[base + AW'(wpos)] <= now_q;

		if (cmd.row_ld) begin
			pass_q <= 1'b1;
			if (in_range && rd_init_q && op_q != OP_RESET) begin
				valid_q <= rd_valid_q;
				lx_q    <= rd_x_q;
				ly_q    <= rd_y_q;
				lz_q    <= rd_z_q;
				susp_q  <= rd_susp_q;
				head_q  <= rd_head_q;
				count_q <= rd_count_q;
			end else begin
				valid_q <= 1'b0;
				lx_q    <= '0;
				ly_q    <= '0;
				lz_q    <= '0;
				susp_q  <= '0;
				head_q  <= '0;
				count_q <= '0;
			end
		end
		if (cmd.pop) begin
			head_q  <= head_inc;
			count_q <= count_q - 1'b1;
		end
		if (cmd.push) begin
			head_q  <= h1;
			count_q <= c_new;
			valid_q <= 1'b1;
			if (32'(c_new) > 32'(cfg.max_pkts)) begin
				pass_q <= 1'b0;
				susp_q <= susp_inc;
			end
		end
		if (cmd.mv_first || cmd.mv_cmp) begin
			valid_q <= 1'b1;
			lx_q    <= x_q;
			ly_q    <= y_q;
			lz_q    <= z_q;
		end
		if (cmd.mv_cmp && ({28'b0, dist_q, 32'b0} > lim_q)) begin
			pass_q <= 1'b0;
			susp_q <= susp_inc;
		end

		if (cmd.diff) begin
			adx_q  <= dx[32] ? 33'(-dx) : 33'(dx);
			ady_q  <= dy[32] ? 33'(-dy) : 33'(dy);
			adz_q  <= dz[32] ? 33'(-dz) : 33'(dz);
			dist_q <= '0;
			lim_q  <= '0;
		end
		if (cmd.mul) begin
			prod_q  <= ma * mb;
			pstep_q <= cmd.mul_step;
			if (pvld_q) begin
				case (pstep_q)
					MS_DX, MS_DY, MS_DZ: dist_q <= dist_q + 68'(prod_q);
					MS_L:  l_q   <= prod_q[62:0];
					MS_LL: lim_q <= lim_q + 128'(prod_q);
					MS_LH: lim_q <= lim_q + (128'(prod_q) << 33);
					MS_HH: lim_q <= lim_q + (128'(prod_q) << 64);
					default: lim_q <= lim_q;
				endcase
			end
		end
	end

	always_comb begin
		status.op          = op_q;
		status.in_range    = in_range;
		status.count_nz    = count_q != '0;
		status.expired     = (now_q - stamp_q) > cfg.window;
		status.entry_valid = valid_q;
		status.dt_pos      = !dt_q[31] && (dt_q != '0);
		result.passed      = pass_q;
		result.susp        = susp_q;
		result.rate        = (32'(count_q) > 127) ? 7'd127 : 7'(count_q);
	end

endmodule

// File: rtl/per_flow_rate_and_speed_monitor_unit.sv
// Per-flow rate and speed monitor. Each input transaction names a player and
// an operation (tuser): packet, movement, query or reset player. A packet
// transaction first pops that player's timestamps that are older than
// window_ticks (modular age), then appends now_time to the player's ring of
// STAMP_DEPTH stamps and flags when more than max_packets_per_window stamps
// remain. A movement transaction flags when the squared distance from the
// stored position exceeds (max_speed * delta_time)^2, computed exactly on one
// shared 33x33 multiplier; a movement of a player with no earlier packet or
// movement only stores the position and a non-positive delta_time skips
// the check. Every flag bumps the player's saturating suspicion count, and
// kick reports whether that count has reached kick_threshold. Exactly one
// result transaction comes out per input transaction, in order.
// Sequence: items are handled one at a time. Query and out-of-range items
// pass table row read, load and result; reset player adds a write back
// before the result. A checked movement runs seven products and a drain
// step in sequence on the shared multiplier, then compare and write back. A
// movement with no stored entry only writes back, and one with a non-positive
// delta_time goes from the difference step straight to the result. A packet,
// while its ring is not empty, reads the oldest stamp through the single read
// port of the stamp memory and compares it, popping it and repeating while it
// has expired; it then pushes and writes back. The result step holds while an earlier result still waits on m_tready.
// A finished result sits in the output register while the next item is
// already accepted. No clearing pass is needed after reset; configuration
// writes are taken on any cycle with cfg_wen high and should be done while
// the block is idle.
module per_flow_rate_and_speed_monitor_unit
	import pfrm_pkg::*;
#(
	parameter int PLAYERS     = 64,
	parameter int STAMP_DEPTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// player[5:0], now_time[37:6], pos_x[69:38], pos_y[101:70],
	// pos_z[133:102], delta_time[165:134], zero pad[167:166]
	input  logic [167:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// passed[0], suspicion_count[16:1], kick[17], packet_rate[24:18], pad[31:25]
	output logic [31:0]  m_tdata,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;
	result_t result;
	logic    out_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pkts  <= MAX_PKTS_RST;
			cfg_q.window    <= WINDOW_RST;
			cfg_q.max_speed <= MAX_SPEED_RST;
			cfg_q.kick_thr  <= KICK_THR_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MAX_PKTS:  cfg_q.max_pkts  <= cfg_data[5:0];
				CFG_WINDOW:    cfg_q.window    <= cfg_data;
				CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data;
				CFG_KICK_THR:  cfg_q.kick_thr  <= cfg_data[15:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// output register: holds one finished transaction while the next is worked
	assign out_busy = m_tvalid && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (cmd.out_load)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			m_tdata <= {7'b0, result.rate, result.susp >= cfg_q.kick_thr,
				result.susp, result.passed};
	end

	pfrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.out_busy (out_busy),
		.status   (status),
		.cmd      (cmd)
	);

	pfrm_dp #(
		.PLAYERS     (PLAYERS),
		.STAMP_DEPTH (STAMP_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.operation  (s_tuser),
		.player     (s_tdata[5:0]),
		.now_time   (s_tdata[37:6]),
		.pos_x      (s_tdata[69:38]),
		.pos_y      (s_tdata[101:70]),
		.pos_z      (s_tdata[133:102]),
		.delta_time (s_tdata[165:134]),
		.status     (status),
		.result     (result)
	);

endmodule
